>>> rtl/core/blec_pkg.sv
package blec_pkg;

    localparam int ProgDepth  = 4096;
    localparam int CellDepth  = 4096;
    localparam int ConstDepth = 1024;
    localparam int LoopDepth  = 256;

    localparam int PW = $clog2(ProgDepth);
    localparam int CW = $clog2(CellDepth);
    localparam int KW = $clog2(ConstDepth);
    localparam int LW = $clog2(LoopDepth);

    localparam logic [15:0] EofCell = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_PROG  = 3'd0,
        CMD_NUM   = 3'd1,
        CMD_CHAR  = 3'd2,
        CMD_LOOP  = 3'd3,
        CMD_START = 3'd4,
        CMD_STEP  = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        OP_END   = 4'd0,
        OP_UP    = 4'd1,
        OP_DOWN  = 4'd2,
        OP_INC   = 4'd3,
        OP_DEC   = 4'd4,
        OP_OUT   = 4'd5,
        OP_IN    = 4'd6,
        OP_FWD   = 4'd7,
        OP_BACK  = 4'd8,
        OP_NUM   = 4'd9,
        OP_CHAR  = 4'd10,
        OP_LHEAD = 4'd11,
        OP_LTAIL = 4'd12
    } t_op;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] index;
        logic [3:0]  opcode;
        logic [11:0] operand;
        logic [15:0] value;
        logic [11:0] location;
        logic [7:0]  in_byte;
        logic        in_eof;
    } t_req;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        input_taken;
        logic        halted;
        logic        failed;
        logic [11:0] program_counter;
    } t_rsp;

    // cell store access from the sequencer
    typedef struct packed {
        logic          rd;
        logic [CW-1:0] raddr;
        logic          wr;
        logic [CW-1:0] waddr;
        logic [15:0]   wdata;
    } t_cell_cmd;

endpackage

>>> rtl/core/blec_ram.sv
module blec_ram #(
    parameter int Depth = 4096,
    parameter int Width = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/core/blec_seq.sv
module blec_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  blec_pkg::t_req         i_req,
    output logic                   o_valid,
    input  logic                   i_stall,
    output blec_pkg::t_rsp         o_rsp,
    output logic                   o_prog_we,
    output logic [blec_pkg::PW-1:0] o_prog_addr,
    output logic                   o_prog_re,
    input  logic [15:0]            i_prog_rdata,
    output logic                   o_num_we,
    output logic                   o_num_re,
    output logic [blec_pkg::KW-1:0] o_num_addr,
    input  logic [15:0]            i_num_rdata,
    output logic                   o_chr_we,
    output logic                   o_chr_re,
    output logic [blec_pkg::KW-1:0] o_chr_addr,
    input  logic [7:0]             i_chr_rdata,
    output logic                   o_loop_we,
    output logic                   o_loop_re,
    output logic [blec_pkg::LW-1:0] o_loop_addr,
    input  logic [27:0]            i_loop_rdata,
    output blec_pkg::t_cell_cmd    o_cell,
    input  logic [15:0]            i_cell_rdata
);

    localparam int PW = blec_pkg::PW;
    localparam int CW = blec_pkg::CW;
    localparam int KW = blec_pkg::KW;
    localparam int LW = blec_pkg::LW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_CELL,
        S_EXEC,
        S_RESP
    } t_state;

    t_state          r_state, n_state;
    blec_pkg::t_req  r_req, n_req;
    blec_pkg::t_rsp  r_rsp, n_rsp;
    logic            r_ovalid, n_ovalid;
    logic [PW-1:0]   r_pc, n_pc;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [KW-1:0]   r_npos, n_npos;
    logic [KW-1:0]   r_cpos, n_cpos;
    logic [LW-1:0]   r_lpos, n_lpos;
    logic            r_halted, n_halted;
    logic            r_failed, n_failed;
    logic [CW-1:0]   r_clr, n_clr;
    logic [15:0]     r_word, n_word;
    logic [CW-1:0]   r_caddr, n_caddr;
    logic            r_locbad, n_locbad;

    logic [3:0]      w_op;
    logic [11:0]     w_arg;
    logic [PW:0]     w_next;
    logic [11:0]     w_loc;
    logic [15:0]     w_lim;
    logic            w_acc;

    // a held response keeps the request side closed
    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    assign w_op  = r_word[15:12];
    assign w_arg = r_word[11:0];
    assign w_loc = i_loop_rdata[27:16];
    assign w_lim = i_loop_rdata[15:0];

    // table addressing: loads use the index, runs use the positions
    always_comb begin
        o_prog_we   = w_acc && i_req.cmd == blec_pkg::CMD_PROG
                      && {4'd0, i_req.index} < 16'(blec_pkg::ProgDepth);
        o_num_we    = w_acc && i_req.cmd == blec_pkg::CMD_NUM
                      && {4'd0, i_req.index} < 16'(blec_pkg::ConstDepth);
        o_chr_we    = w_acc && i_req.cmd == blec_pkg::CMD_CHAR
                      && {4'd0, i_req.index} < 16'(blec_pkg::ConstDepth);
        o_loop_we   = w_acc && i_req.cmd == blec_pkg::CMD_LOOP
                      && {4'd0, i_req.index} < 16'(blec_pkg::LoopDepth);
        o_prog_re   = w_acc && i_req.cmd == blec_pkg::CMD_STEP && !r_halted;
        o_num_re    = o_prog_re;
        o_chr_re    = o_prog_re;
        o_loop_re   = o_prog_re;
        o_prog_addr = w_acc && i_req.cmd == blec_pkg::CMD_STEP ? r_pc : PW'(i_req.index);
        o_num_addr  = w_acc && i_req.cmd == blec_pkg::CMD_STEP ? r_npos : KW'(i_req.index);
        o_chr_addr  = w_acc && i_req.cmd == blec_pkg::CMD_STEP ? r_cpos : KW'(i_req.index);
        o_loop_addr = w_acc && i_req.cmd == blec_pkg::CMD_STEP ? r_lpos : LW'(i_req.index);
    end

    // sequencer: fetch word, read cell, modify and write back
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_rsp    = r_rsp;
        n_ovalid = r_ovalid;
        n_pc     = r_pc;
        n_ptr    = r_ptr;
        n_npos   = r_npos;
        n_cpos   = r_cpos;
        n_lpos   = r_lpos;
        n_halted = r_halted;
        n_failed = r_failed;
        n_clr    = r_clr;
        n_word   = r_word;
        n_caddr  = r_caddr;
        n_locbad = r_locbad;
        o_cell   = '0;
        w_next   = {1'b0, r_pc} + 1'b1;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_req = i_req;
                    case (i_req.cmd)
                        blec_pkg::CMD_START: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        blec_pkg::CMD_STEP: begin
                            n_state = r_halted ? S_RESP : S_FETCH;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                    n_rsp = '0;
                end
            end
            S_CLEAR: begin
                o_cell.wr    = 1'b1;
                o_cell.waddr = r_clr;
                o_cell.wdata = '0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == CW'(blec_pkg::CellDepth - 1)) begin
                    n_pc     = '0;
                    n_ptr    = '0;
                    n_npos   = '0;
                    n_cpos   = '0;
                    n_lpos   = '0;
                    n_halted = 1'b0;
                    n_failed = 1'b0;
                    n_state  = S_RESP;
                end
            end
            S_FETCH: begin
                n_word = i_prog_rdata;
                if (i_prog_rdata[15:12] == blec_pkg::OP_LHEAD
                        || i_prog_rdata[15:12] == blec_pkg::OP_LTAIL) begin
                    n_caddr  = CW'(w_loc);
                    n_locbad = {4'd0, w_loc} >= 16'(blec_pkg::CellDepth);
                end else begin
                    n_caddr  = r_ptr;
                    n_locbad = 1'b0;
                end
                n_state = S_CELL;
            end
            S_CELL: begin
                o_cell.rd    = 1'b1;
                o_cell.raddr = r_caddr;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
                o_cell.waddr = r_caddr;
                case (w_op)
                    blec_pkg::OP_END: begin
                        n_halted = 1'b1;
                        n_failed = 1'b0;
                        w_next   = {1'b0, r_pc};
                    end
                    blec_pkg::OP_UP: begin
                        if ({1'b0, r_ptr} + 1'b1 >= (CW+1)'(blec_pkg::CellDepth)) begin
                            n_halted = 1'b1;
                            n_failed = 1'b1;
                        end else begin
                            n_ptr = r_ptr + 1'b1;
                        end
                    end
                    blec_pkg::OP_DOWN: begin
                        if (r_ptr == '0) begin
                            n_halted = 1'b1;
                            n_failed = 1'b1;
                        end else begin
                            n_ptr = r_ptr - 1'b1;
                        end
                    end
                    blec_pkg::OP_INC: begin
                        o_cell.wr    = 1'b1;
                        o_cell.wdata = i_cell_rdata + 1'b1;
                    end
                    blec_pkg::OP_DEC: begin
                        o_cell.wr    = 1'b1;
                        o_cell.wdata = i_cell_rdata - 1'b1;
                    end
                    blec_pkg::OP_OUT: begin
                        n_rsp.out_valid = 1'b1;
                        n_rsp.out_byte  = i_cell_rdata[7:0];
                    end
                    blec_pkg::OP_IN: begin
                        o_cell.wr = 1'b1;
                        if (r_req.in_eof) begin
                            o_cell.wdata = blec_pkg::EofCell;
                        end else begin
                            o_cell.wdata      = {8'd0, r_req.in_byte};
                            n_rsp.input_taken = 1'b1;
                        end
                    end
                    blec_pkg::OP_FWD: begin
                        if (i_cell_rdata == '0) begin
                            w_next = (PW+1)'(w_arg) + 1'b1;
                        end
                    end
                    blec_pkg::OP_BACK: begin
                        if (i_cell_rdata != '0) begin
                            w_next = (PW+1)'(w_arg) + 1'b1;
                        end
                    end
                    blec_pkg::OP_NUM: begin
                        o_cell.wr    = 1'b1;
                        o_cell.wdata = i_num_rdata;
                        n_npos = ({1'b0, r_npos} + 1'b1 >= (KW+1)'(blec_pkg::ConstDepth))
                                 ? '0 : r_npos + 1'b1;
                    end
                    blec_pkg::OP_CHAR: begin
                        o_cell.wr    = 1'b1;
                        o_cell.wdata = {8'd0, i_chr_rdata};
                        n_cpos = ({1'b0, r_cpos} + 1'b1 >= (KW+1)'(blec_pkg::ConstDepth))
                                 ? '0 : r_cpos + 1'b1;
                    end
                    blec_pkg::OP_LHEAD, blec_pkg::OP_LTAIL: begin
                        if (r_locbad) begin
                            n_halted = 1'b1;
                            n_failed = 1'b1;
                            w_next   = {1'b0, r_pc};
                        end else if (i_cell_rdata < w_lim) begin
                            o_cell.wr    = 1'b1;
                            o_cell.wdata = i_cell_rdata + 1'b1;
                            if (w_op == blec_pkg::OP_LTAIL) begin
                                w_next = (PW+1)'(w_arg) + 1'b1;
                            end
                        end else if (w_op == blec_pkg::OP_LTAIL) begin
                            n_lpos = ({1'b0, r_lpos} + 1'b1
                                      >= (LW+1)'(blec_pkg::LoopDepth))
                                     ? '0 : r_lpos + 1'b1;
                        end
                    end
                    default: begin
                        n_halted = 1'b1;
                        n_failed = 1'b1;
                        w_next   = {1'b0, r_pc};
                    end
                endcase
                // next address past the program fails in place
                if (w_next >= (PW+1)'(blec_pkg::ProgDepth)) begin
                    n_halted = 1'b1;
                    n_failed = 1'b1;
                end else begin
                    n_pc = w_next[PW-1:0];
                end
            end
            S_RESP: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid              = 1'b1;
                    n_rsp.halted          = r_halted;
                    n_rsp.failed          = r_failed;
                    n_rsp.program_counter = 12'(r_pc);
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
            r_ptr    <= '0;
            r_npos   <= '0;
            r_cpos   <= '0;
            r_lpos   <= '0;
            r_halted <= 1'b1;
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pc     <= n_pc;
            r_ptr    <= n_ptr;
            r_npos   <= n_npos;
            r_cpos   <= n_cpos;
            r_lpos   <= n_lpos;
            r_halted <= n_halted;
            r_failed <= n_failed;
        end
        r_req    <= n_req;
        r_rsp    <= n_rsp;
        r_clr    <= n_clr;
        r_word   <= n_word;
        r_caddr  <= n_caddr;
        r_locbad <= n_locbad;
    end

endmodule

>>> rtl/core/bracket_language_execution_core.sv
// channel   | valid    | stall    | payload
// request   | i_valid  | o_stall  | i_req  (blec_pkg::t_req)
// response  | o_valid  | i_stall  | o_rsp  (blec_pkg::t_rsp)
//
// load and unknown requests, and a step on a halted core, go straight to the
// response register; any other step passes program and table fetch, cell read,
// modify and write back, response register. a start sweeps one cell a cycle.
// reset is synchronous; it leaves the core halted with the tables unwritten.
// a stalled response holds the core; no new request is taken until it leaves.
module bracket_language_execution_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  blec_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output blec_pkg::t_rsp o_rsp
);

    localparam int PW = blec_pkg::PW;
    localparam int KW = blec_pkg::KW;
    localparam int LW = blec_pkg::LW;

    logic          w_prog_we, w_prog_re, w_num_we, w_num_re;
    logic          w_chr_we, w_chr_re, w_loop_we, w_loop_re;
    logic [PW-1:0] w_prog_addr;
    logic [KW-1:0] w_num_addr, w_chr_addr;
    logic [LW-1:0] w_loop_addr;
    logic [15:0]   w_prog_rdata, w_num_rdata, w_cell_rdata;
    logic [7:0]    w_chr_rdata;
    logic [27:0]   w_loop_rdata;
    blec_pkg::t_cell_cmd w_cell;

    // control sequencer
    blec_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .o_prog_we(w_prog_we), .o_prog_addr(w_prog_addr), .o_prog_re(w_prog_re),
        .i_prog_rdata(w_prog_rdata),
        .o_num_we(w_num_we), .o_num_re(w_num_re), .o_num_addr(w_num_addr),
        .i_num_rdata(w_num_rdata),
        .o_chr_we(w_chr_we), .o_chr_re(w_chr_re), .o_chr_addr(w_chr_addr),
        .i_chr_rdata(w_chr_rdata),
        .o_loop_we(w_loop_we), .o_loop_re(w_loop_re), .o_loop_addr(w_loop_addr),
        .i_loop_rdata(w_loop_rdata),
        .o_cell(w_cell), .i_cell_rdata(w_cell_rdata)
    );

    // program store
    blec_ram #(.Depth(blec_pkg::ProgDepth), .Width(16)) u_prog (
        .i_clk(i_clk), .i_we(w_prog_we), .i_waddr(w_prog_addr),
        .i_wdata({i_req.opcode, i_req.operand}),
        .i_re(w_prog_re), .i_raddr(w_prog_addr), .o_rdata(w_prog_rdata)
    );

    // data cells
    blec_ram #(.Depth(blec_pkg::CellDepth), .Width(16)) u_cell (
        .i_clk(i_clk), .i_we(w_cell.wr), .i_waddr(w_cell.waddr),
        .i_wdata(w_cell.wdata),
        .i_re(w_cell.rd), .i_raddr(w_cell.raddr), .o_rdata(w_cell_rdata)
    );

    // number constants
    blec_ram #(.Depth(blec_pkg::ConstDepth), .Width(16)) u_num (
        .i_clk(i_clk), .i_we(w_num_we), .i_waddr(w_num_addr),
        .i_wdata(i_req.value),
        .i_re(w_num_re), .i_raddr(w_num_addr), .o_rdata(w_num_rdata)
    );

    // character constants
    blec_ram #(.Depth(blec_pkg::ConstDepth), .Width(8)) u_chr (
        .i_clk(i_clk), .i_we(w_chr_we), .i_waddr(w_chr_addr),
        .i_wdata(i_req.value[7:0]),
        .i_re(w_chr_re), .i_raddr(w_chr_addr), .o_rdata(w_chr_rdata)
    );

    // counted loop entries, location and limit side by side
    blec_ram #(.Depth(blec_pkg::LoopDepth), .Width(28)) u_loop (
        .i_clk(i_clk), .i_we(w_loop_we), .i_waddr(w_loop_addr),
        .i_wdata({i_req.location, i_req.value}),
        .i_re(w_loop_re), .i_raddr(w_loop_addr), .o_rdata(w_loop_rdata)
    );

endmodule

>>> rtl/core/blec_chk.sv
module blec_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input blec_pkg::t_rsp o_rsp
);

    // a held response keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed under stall");

    // output byte only with its flag
    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.out_valid |-> o_rsp.out_byte == 8'd0)
        else $error("stray output byte");

    // failure implies halt
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.failed |-> o_rsp.halted)
        else $error("failed without halted");

    // no response without a request in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("response without request");

endmodule

bind bracket_language_execution_core blec_chk u_chk (.*);
